FILE: rtl/rkds_pkg.sv
// Shared constants and types for the RK4 driven spring step block.
`default_nettype none
package rkds_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int IO_BITS       = 32;
    localparam int TICK_BITS     = 16;
    localparam int CFG_IDX_BITS  = 3;

    // step constants: dt, half step, step over six
    localparam int NUM_LANES = 3;
    localparam int LANE_DIVISOR [NUM_LANES] = '{1000, 2000, 6000};
    localparam int LANE_BIAS    [NUM_LANES] = '{500, 1000, 3000};
    localparam int REM_BITS     = 14;

    localparam logic [2:0] LAST_STAGE = 3'd4;
    localparam logic [2:0] LAST_OP    = 3'd4;
    localparam logic [2:0] FIRST_DERIV_OP = 3'd2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SPRING_GAIN    = 3'd0,
        CFG_DAMPING_GAIN   = 3'd1,
        CFG_INVERSE_MASS   = 3'd2,
        CFG_START_POSITION = 3'd3,
        CFG_START_VELOCITY = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_ARGX,
        OP_ARGV,
        OP_PULL,
        OP_DRAG,
        OP_DERIV,
        OP_POS,
        OP_VEL
    } op_t;

endpackage
`default_nettype wire

FILE: rtl/rkds_ifs.sv
// Valid/ready channel interfaces: step input, result output, config write.
`default_nettype none
interface rkds_in_if;
    logic               valid;
    logic               ready;
    logic               running;
    logic        [15:0] step_ticks;
    logic signed [31:0] drive_pos_start;
    logic signed [31:0] drive_pos_mid;
    logic signed [31:0] drive_pos_end;
    logic signed [31:0] force_start;
    logic signed [31:0] force_mid;
    logic signed [31:0] force_end;

    modport source (output valid, running, step_ticks, drive_pos_start, drive_pos_mid,
                    drive_pos_end, force_start, force_mid, force_end, input ready);
    modport sink   (input valid, running, step_ticks, drive_pos_start, drive_pos_mid,
                    drive_pos_end, force_start, force_mid, force_end, output ready);
endinterface

interface rkds_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;

    modport source (output valid, position, velocity, acceleration, input ready);
    modport sink   (input valid, position, velocity, acceleration, output ready);
endinterface

interface rkds_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/rk4_driven_spring_step_top.sv
// Top level: RK4 step sequencer for a driven, damped spring in fixed point.
// A running word takes 23 serial multiplies; a held word takes none and goes
// straight from acceptance to the output registers.
// Throughput: one word at a time, set by the single shared bit-serial multiplier.
// Reset: position, velocity, their start registers and acceleration clear;
// gains reset to one, damping to zero. No clearing pass.
`default_nettype none
module rk4_driven_spring_step_top #(
    parameter int FRAC_BITS = rkds_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = rkds_pkg::WORD_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    rkds_in_if.sink    step_in,
    rkds_out_if.source step_out,
    rkds_cfg_if.sink   cfg
);
    import rkds_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int BW = WORD_BITS + 3;
    localparam int IW = (W > IO_BITS) ? W : IO_BITS;
    localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;

    function automatic logic signed [W-1:0] from_io(input logic signed [IO_BITS-1:0] v);
        logic signed [IW-1:0] e;
        logic [IW-W:0]        hi;
        e  = IW'(v);
        hi = e[IW-1:W-1];
        if ((&hi) || !(|hi))
            return signed'(e[W-1:0]);
        return e[IW-1] ? signed'({1'b1, {(W-1){1'b0}}}) : signed'({1'b0, {(W-1){1'b1}}});
    endfunction

    function automatic logic signed [IO_BITS-1:0] to_io(input logic signed [W-1:0] v);
        logic signed [IW-1:0] e;
        logic [IW-IO_BITS:0]  hi;
        e  = IW'(v);
        hi = e[IW-1:IO_BITS-1];
        if ((&hi) || !(|hi))
            return signed'(e[IO_BITS-1:0]);
        return e[IW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic signed [W-1:0] sat1(input logic signed [W:0] v);
        if (v[W] != v[W-1])
            return v[W] ? signed'({1'b1, {(W-1){1'b0}}}) : signed'({1'b0, {(W-1){1'b1}}});
        return signed'(v[W-1:0]);
    endfunction

    state_t state_reg, state_next;
    logic [2:0] stage_reg, op_reg;
    logic       out_valid_reg;
    logic       in_accept, out_load, mul_start, mul_done, last_op;
    op_t        op;

    logic signed [W-1:0] spring_gain_reg, damping_gain_reg, inverse_mass_reg;
    logic signed [W-1:0] start_pos_reg, start_vel_reg;
    logic signed [W-1:0] pos_reg, vel_reg, acc_reg;
    logic signed [W-1:0] tx_reg, tv_reg, kv_reg, pull_reg;
    logic signed [W:0]   diff_reg;
    logic signed [BW-1:0] sumx_reg, sumv_reg;
    logic signed [W-1:0] w_reg [3];
    logic signed [W-1:0] h_reg [3];
    logic signed [IO_BITS-1:0] pos_out_reg, vel_out_reg, acc_out_reg;

    logic signed [W-1:0]  dt, hdt, dt6, coef, w_sel, h_sel, mul_res;
    logic signed [W-1:0]  mul_a, new_tx, new_tv;
    logic signed [BW-1:0] mul_b;
    logic [1:0]           sample_sel;
    logic                 weight2;

    assign in_accept = step_in.valid && step_in.ready;
    assign last_op   = (stage_reg == LAST_STAGE) && (op_reg == LAST_OP);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_accept) state_next = step_in.running ? ST_ISSUE : ST_FIN;
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT:  if (mul_done) state_next = last_op ? ST_FIN : ST_ISSUE;
            ST_FIN:   if (!out_valid_reg || step_out.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        step_in.ready = 1'b0;
        mul_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:  step_in.ready = 1'b1;
            ST_ISSUE: mul_start = 1'b1;
            ST_WAIT:  ;
            ST_FIN:   out_load = !out_valid_reg || step_out.ready;
            default:  ;
        endcase
    end

    // op decode: stage 0 runs only the derivative, stage 4 updates then recomputes acc
    always_comb
    begin
        case (op_reg)
            3'd0:    op = (stage_reg == LAST_STAGE) ? OP_POS : OP_ARGX;
            3'd1:    op = (stage_reg == LAST_STAGE) ? OP_VEL : OP_ARGV;
            3'd2:    op = OP_PULL;
            3'd3:    op = OP_DRAG;
            default: op = OP_DERIV;
        endcase
        case (stage_reg)
            3'd1, 3'd2: sample_sel = 2'd1;
            3'd3:       sample_sel = 2'd2;
            default:    sample_sel = 2'd0;
        endcase
        weight2 = (stage_reg == 3'd1) || (stage_reg == 3'd2);
        coef    = (stage_reg == 3'd3) ? dt : hdt;
        w_sel   = w_reg[sample_sel];
        h_sel   = h_reg[sample_sel];
    end

    always_comb
    begin
        case (op)
            OP_ARGX:  begin mul_a = coef;             mul_b = BW'(tv_reg); end
            OP_ARGV:  begin mul_a = coef;             mul_b = BW'(kv_reg); end
            OP_PULL:  begin mul_a = spring_gain_reg;  mul_b = BW'(w_sel) - BW'(tx_reg); end
            OP_DRAG:  begin mul_a = damping_gain_reg; mul_b = BW'(tv_reg); end
            OP_DERIV: begin mul_a = inverse_mass_reg; mul_b = BW'(diff_reg) + BW'(h_sel); end
            OP_POS:   begin mul_a = dt6;              mul_b = sumx_reg; end
            OP_VEL:   begin mul_a = dt6;              mul_b = sumv_reg; end
            default:  begin mul_a = '0;               mul_b = '0; end
        endcase
    end

    assign new_tx = sat1((W+1)'(pos_reg) + (W+1)'(mul_res));
    assign new_tv = sat1((W+1)'(vel_reg) + (W+1)'(mul_res));

    rkds_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    // started at accept; finishes well before the first stage that needs it
    rkds_tdiv #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_tdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .ticks (step_in.step_ticks),
        .dt    (dt),
        .hdt   (hdt),
        .dt6   (dt6)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stage_reg        <= '0;
            op_reg           <= '0;
            out_valid_reg    <= 1'b0;
            spring_gain_reg  <= ONE;
            damping_gain_reg <= '0;
            inverse_mass_reg <= ONE;
            start_pos_reg    <= '0;
            start_vel_reg    <= '0;
            pos_reg          <= '0;
            vel_reg          <= '0;
            acc_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (step_out.ready)
                out_valid_reg <= 1'b0;

            if (in_accept)
            begin
                stage_reg <= '0;
                op_reg    <= FIRST_DERIV_OP;
            end
            else if ((state_reg == ST_WAIT) && mul_done)
            begin
                if (op_reg == LAST_OP)
                begin
                    stage_reg <= stage_reg + 3'd1;
                    op_reg    <= '0;
                end
                else
                begin
                    op_reg <= op_reg + 3'd1;
                end
            end

            if ((state_reg == ST_WAIT) && mul_done)
            begin
                if (op == OP_POS)
                    pos_reg <= new_tx;
                if (op == OP_VEL)
                    vel_reg <= new_tv;
                if ((op == OP_DERIV) && (stage_reg == LAST_STAGE))
                    acc_reg <= mul_res;
            end

            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_SPRING_GAIN:    spring_gain_reg  <= from_io(cfg.data);
                    CFG_DAMPING_GAIN:   damping_gain_reg <= from_io(cfg.data);
                    CFG_INVERSE_MASS:   inverse_mass_reg <= from_io(cfg.data);
                    CFG_START_POSITION:
                    begin
                        start_pos_reg <= from_io(cfg.data);
                        pos_reg       <= from_io(cfg.data);
                    end
                    CFG_START_VELOCITY:
                    begin
                        start_vel_reg <= from_io(cfg.data);
                        vel_reg       <= from_io(cfg.data);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            w_reg[0] <= from_io(step_in.drive_pos_start);
            w_reg[1] <= from_io(step_in.drive_pos_mid);
            w_reg[2] <= from_io(step_in.drive_pos_end);
            h_reg[0] <= from_io(step_in.force_start);
            h_reg[1] <= from_io(step_in.force_mid);
            h_reg[2] <= from_io(step_in.force_end);
            tx_reg   <= pos_reg;
            tv_reg   <= vel_reg;
            sumx_reg <= BW'(vel_reg);
            sumv_reg <= '0;
        end
        else if ((state_reg == ST_WAIT) && mul_done)
        begin
            case (op)
                OP_ARGX: tx_reg <= new_tx;
                OP_ARGV:
                begin
                    tv_reg   <= new_tv;
                    sumx_reg <= sumx_reg + (weight2 ? (BW'(new_tv) <<< 1) : BW'(new_tv));
                end
                OP_PULL: pull_reg <= mul_res;
                OP_DRAG: diff_reg <= (W+1)'(pull_reg) - (W+1)'(mul_res);
                OP_DERIV:
                begin
                    kv_reg   <= mul_res;
                    sumv_reg <= sumv_reg + (weight2 ? (BW'(mul_res) <<< 1) : BW'(mul_res));
                end
                OP_POS:  tx_reg <= new_tx;
                OP_VEL:  tv_reg <= new_tv;
                default: ;
            endcase
        end
        if (out_load)
        begin
            pos_out_reg <= to_io(pos_reg);
            vel_out_reg <= to_io(vel_reg);
            acc_out_reg <= to_io(acc_reg);
        end
    end

    assign cfg.ready             = 1'b1;
    assign step_out.valid        = out_valid_reg;
    assign step_out.position     = pos_out_reg;
    assign step_out.velocity     = vel_out_reg;
    assign step_out.acceleration = acc_out_reg;

endmodule
`default_nettype wire

FILE: rtl/rkds_mul.sv
// Bit-serial signed fixed-point multiplier with floor shift and saturation.
`default_nettype none
module rkds_mul #(
    parameter int WORD_BITS = rkds_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rkds_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [WORD_BITS-1:0] a,
    input  wire logic signed [WORD_BITS+2:0] b,
    output logic                             done,
    output logic signed [WORD_BITS-1:0]      result
);
    import rkds_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int BW = WORD_BITS + 3;
    localparam int PW = W + BW;
    localparam int CW = $clog2(BW + 1);
    localparam logic [PW-1:0] MAG_MAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};

    logic          busy_reg, fin_reg, done_reg, neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  ua_reg;
    logic [PW-1:0] prod_reg;
    logic signed [W-1:0] res_reg;

    logic [W:0]    psum;
    logic [PW-1:0] qmag;
    logic signed [W-1:0] res_next;

    // add-then-shift, LSB of the multiplier first
    assign psum = prod_reg[0] ? ({1'b0, prod_reg[PW-1:BW]} + {1'b0, ua_reg})
                              : {1'b0, prod_reg[PW-1:BW]};

    always_comb
    begin
        qmag = (prod_reg >> FRAC_BITS)
             + PW'(neg_reg && (prod_reg[FRAC_BITS-1:0] != '0));
        if (!neg_reg)
        begin
            res_next = (qmag > MAG_MAX) ? signed'(W'(MAG_MAX)) : signed'(qmag[W-1:0]);
        end
        else
        begin
            res_next = (qmag > MAG_MAX + PW'(1)) ? signed'({1'b1, {(W-1){1'b0}}})
                                                : signed'(W'(-qmag));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(BW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= a[W-1] ^ b[BW-1];
            ua_reg   <= a[W-1] ? W'(-a) : W'(a);
            prod_reg <= {{W{1'b0}}, (b[BW-1] ? BW'(-b) : BW'(b))};
        end
        else if (busy_reg)
        begin
            prod_reg <= {psum, prod_reg[BW-1:1]};
        end
        if (fin_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

FILE: rtl/rkds_tdiv.sv
// Bit-serial division of the tick count by 1000, 2000 and 6000 with rounding.
`default_nettype none
module rkds_tdiv #(
    parameter int WORD_BITS = rkds_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rkds_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [15:0]                 ticks,
    output logic signed [WORD_BITS-1:0]      dt,
    output logic signed [WORD_BITS-1:0]      hdt,
    output logic signed [WORD_BITS-1:0]      dt6
);
    import rkds_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int NUMW = TICK_BITS + FRAC_BITS + 1;
    localparam int CW   = $clog2(NUMW + 1);
    localparam logic [NUMW-1:0] Q_MAX = NUMW'({(W-1){1'b1}});

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [NUMW-1:0]     n_reg [NUM_LANES];
    logic [REM_BITS-1:0] r_reg [NUM_LANES];
    logic signed [W-1:0] q_sat [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NUMW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        localparam logic [REM_BITS-1:0] DIV = REM_BITS'(LANE_DIVISOR[i]);
        logic [REM_BITS-1:0] trial;
        logic                ge;

        assign trial = {r_reg[i][REM_BITS-2:0], n_reg[i][NUMW-1]};
        assign ge    = trial >= DIV;

        // restoring long division; quotient bits shift in behind the dividend
        always_ff @(posedge clk)
        begin
            if (start)
            begin
                n_reg[i] <= ({1'b0, ticks, {FRAC_BITS{1'b0}}}) + NUMW'(LANE_BIAS[i]);
                r_reg[i] <= '0;
            end
            else if (busy_reg)
            begin
                r_reg[i] <= ge ? trial - DIV : trial;
                n_reg[i] <= {n_reg[i][NUMW-2:0], ge};
            end
        end

        assign q_sat[i] = (n_reg[i] > Q_MAX) ? signed'(W'(Q_MAX)) : signed'(W'(n_reg[i]));
    end

    assign dt  = q_sat[0];
    assign hdt = q_sat[1];
    assign dt6 = q_sat[2];

endmodule
`default_nettype wire

FILE: dv/rkds_tb_ifs_note.sv
// Testbench-side helper types for the RK4 driven spring step bench.
`timescale 1ns / 100ps
package rkds_tb_pkg;

    typedef struct packed {
        logic               running;
        logic        [15:0] step_ticks;
        logic signed [31:0] drive_pos_start;
        logic signed [31:0] drive_pos_mid;
        logic signed [31:0] drive_pos_end;
        logic signed [31:0] force_start;
        logic signed [31:0] force_mid;
        logic signed [31:0] force_end;
    } step_word_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
    } state_word_t;

endpackage

FILE: dv/rk4_driven_spring_step_top_tb.sv
// Testbench for the RK4 driven spring step block: fixed-point predictor and scoreboard.
`timescale 1ns / 100ps
module rk4_driven_spring_step_top_tb;
    import rkds_pkg::*;
    import rkds_tb_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int     SETTLE_CYCLES = 1000;
    localparam longint CYCLE_LIMIT = 64'd6000000;

    logic clk;
    logic rst_n;

    rkds_in_if  step_in ();
    rkds_out_if step_out ();
    rkds_cfg_if cfg ();

    rk4_driven_spring_step_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_in  (step_in),
        .step_out (step_out),
        .cfg      (cfg)
    );

    // model copy of registers and state
    longint spring_gain, damping_gain, inverse_mass;
    longint pos_q, vel_q, acc_q;

    step_word_t  pending_steps [$];
    state_word_t expected_states [$];
    int     errors;
    int     results_seen;
    int     held_seen;
    longint cycle_count;
    bit     hold_off;
    bit     stim_done;
    int     drive_gap;
    int     sink_gap;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sat(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    // exact product, floor shift, saturate
    function automatic longint qmul(longint a, longint b);
        logic signed [127:0] p;
        p = (128'(signed'(a)) * 128'(signed'(b))) >>> 16;
        if (p > 128'(signed'(WMAX))) return WMAX;
        if (p < 128'(signed'(WMIN))) return WMIN;
        return longint'(p);
    endfunction

    function automatic longint madd(longint base, longint coef, longint slope);
        return sat(base + qmul(coef, slope));
    endfunction

    function automatic longint accel_of(longint x, longint v, longint w, longint h);
        longint pull, drag;
        pull = qmul(spring_gain, w - x);
        drag = qmul(damping_gain, v);
        return qmul(inverse_mass, pull - drag + h);
    endfunction

    function automatic state_word_t rk4_advance(step_word_t s);
        state_word_t r;
        longint num, dt, hdt, dt6, x, v;
        longint k1x, k1v, k2x, k2v, k3x, k3v, k4x, k4v;
        if (s.running)
        begin
            num = longint'(s.step_ticks) << 16;
            dt  = sat((num + 500) / 1000);
            hdt = sat((num + 1000) / 2000);
            dt6 = sat((num + 3000) / 6000);
            x = pos_q;
            v = vel_q;
            k1x = v;
            k1v = accel_of(x, v, s.drive_pos_start, s.force_start);
            k2x = madd(v, hdt, k1v);
            k2v = accel_of(madd(x, hdt, k1x), k2x, s.drive_pos_mid, s.force_mid);
            k3x = madd(v, hdt, k2v);
            k3v = accel_of(madd(x, hdt, k2x), k3x, s.drive_pos_mid, s.force_mid);
            k4x = madd(v, dt, k3v);
            k4v = accel_of(madd(x, dt, k3x), k4x, s.drive_pos_end, s.force_end);
            pos_q = sat(x + qmul(dt6, k1x + 2 * k2x + 2 * k3x + k4x));
            vel_q = sat(v + qmul(dt6, k1v + 2 * k2v + 2 * k3v + k4v));
            acc_q = accel_of(pos_q, vel_q, s.drive_pos_start, s.force_start);
        end
        r.position     = pos_q[31:0];
        r.velocity     = vel_q[31:0];
        r.acceleration = acc_q[31:0];
        return r;
    endfunction

    function automatic int short_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 3);
        return 0;
    endfunction

    // driver: steps are predicted as they are accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_in.valid <= 1'b0;
            drive_gap     <= 0;
        end
        else
        begin
            if (step_in.valid && step_in.ready)
            begin
                expected_states.push_back(rk4_advance({step_in.running, step_in.step_ticks,
                    step_in.drive_pos_start, step_in.drive_pos_mid, step_in.drive_pos_end,
                    step_in.force_start, step_in.force_mid, step_in.force_end}));
                if (!step_in.running) held_seen++;
            end
            if (!step_in.valid || step_in.ready)
            begin
                if (drive_gap > 0)
                begin
                    step_in.valid <= 1'b0;
                    drive_gap <= drive_gap - 1;
                end
                else if (pending_steps.size() > 0)
                begin
                    step_word_t s;
                    s = pending_steps.pop_front();
                    step_in.valid           <= 1'b1;
                    step_in.running         <= s.running;
                    step_in.step_ticks      <= s.step_ticks;
                    step_in.drive_pos_start <= s.drive_pos_start;
                    step_in.drive_pos_mid   <= s.drive_pos_mid;
                    step_in.drive_pos_end   <= s.drive_pos_end;
                    step_in.force_start     <= s.force_start;
                    step_in.force_mid       <= s.force_mid;
                    step_in.force_end       <= s.force_end;
                    drive_gap <= short_gap();
                end
                else
                    step_in.valid <= 1'b0;
            end
        end
    end

    // monitor and result-side backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_out.ready <= 1'b0;
            sink_gap       <= 0;
        end
        else
        begin
            if (step_out.valid && step_out.ready)
            begin
                state_word_t e;
                results_seen++;
                if (expected_states.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_states.pop_front();
                    if (step_out.position !== e.position)
                    begin
                        $error("position: expected %0d got %0d", e.position, step_out.position);
                        errors++;
                    end
                    if (step_out.velocity !== e.velocity)
                    begin
                        $error("velocity: expected %0d got %0d", e.velocity, step_out.velocity);
                        errors++;
                    end
                    if (step_out.acceleration !== e.acceleration)
                    begin
                        $error("acceleration: expected %0d got %0d",
                               e.acceleration, step_out.acceleration);
                        errors++;
                    end
                end
            end
            if (hold_off)
                step_out.ready <= 1'b0;
            else if (sink_gap > 0)
            begin
                step_out.ready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end
            else
            begin
                step_out.ready <= 1'b1;
                sink_gap <= short_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic step_word_t rand_step();
        step_word_t s;
        s.running = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 4))
            0: s.step_ticks = 16'($urandom);
            1: s.step_ticks = 16'hFFFF;
            default: s.step_ticks = 16'($urandom_range(0, 200));
        endcase
        s.drive_pos_start = rand_q();
        s.drive_pos_mid   = rand_q();
        s.drive_pos_end   = rand_q();
        s.force_start     = rand_q();
        s.force_mid       = rand_q();
        s.force_end       = rand_q();
        return s;
    endfunction

    // checked mid-cycle so the driver's pop and valid update are both settled
    task automatic wait_drained();
        while (pending_steps.size() > 0 || step_in.valid || expected_states.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_SPRING_GAIN:    spring_gain  = longint'($signed(value));
            CFG_DAMPING_GAIN:   damping_gain = longint'($signed(value));
            CFG_INVERSE_MASS:   inverse_mass = longint'($signed(value));
            CFG_START_POSITION: pos_q        = longint'($signed(value));
            CFG_START_VELOCITY: vel_q        = longint'($signed(value));
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [31:0] k, logic [31:0] c, logic [31:0] im,
                                logic [31:0] x0, logic [31:0] v0);
        write_reg(CFG_SPRING_GAIN, k);
        write_reg(CFG_DAMPING_GAIN, c);
        write_reg(CFG_INVERSE_MASS, im);
        write_reg(CFG_START_POSITION, x0);
        write_reg(CFG_START_VELOCITY, v0);
    endtask

    initial
    begin
        step_word_t s;
        errors = 0;
        results_seen = 0;
        held_seen = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        step_in.valid = 1'b0;
        step_in.running = 1'b0;
        step_in.step_ticks = '0;
        step_in.drive_pos_start = '0;
        step_in.drive_pos_mid = '0;
        step_in.drive_pos_end = '0;
        step_in.force_start = '0;
        step_in.force_mid = '0;
        step_in.force_end = '0;
        step_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_SPRING_GAIN;
        cfg.data = '0;
        spring_gain = 65536;
        damping_gain = 0;
        inverse_mass = 65536;
        pos_q = 0;
        vel_q = 0;
        acc_q = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, field extremes, held steps, zero step
        s = '0;
        pending_steps.push_back(s);
        s.running = 1'b1;
        s.step_ticks = 16'd10;
        s.drive_pos_start = 32'sh0001_0000;
        s.drive_pos_mid = 32'sh0001_0000;
        s.drive_pos_end = 32'sh0001_0000;
        pending_steps.push_back(s);
        s.step_ticks = 16'd0;
        pending_steps.push_back(s);
        s.step_ticks = 16'hFFFF;
        pending_steps.push_back(s);
        s.drive_pos_start = 32'sh7FFFFFFF; s.drive_pos_mid = 32'sh7FFFFFFF;
        s.drive_pos_end = 32'sh7FFFFFFF; s.force_start = 32'sh7FFFFFFF;
        s.force_mid = 32'sh7FFFFFFF; s.force_end = 32'sh7FFFFFFF;
        pending_steps.push_back(s);
        s.drive_pos_start = 32'sh80000000; s.drive_pos_mid = 32'sh80000000;
        s.drive_pos_end = 32'sh80000000; s.force_start = 32'sh80000000;
        s.force_mid = 32'sh80000000; s.force_end = 32'sh80000000;
        pending_steps.push_back(s);
        s.running = 1'b0;
        pending_steps.push_back(s);
        s = '1;
        pending_steps.push_back(s);
        s.step_ticks = 16'd1;
        pending_steps.push_back(s);
        wait_drained();

        // extreme settings: negative gains, max damping, full-scale presets
        load_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 6; i++) pending_steps.push_back(rand_step());
        wait_drained();
        load_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF);
        for (int i = 0; i < 6; i++) pending_steps.push_back(rand_step());
        wait_drained();

        // stall the result side long enough for the input to back up
        hold_off = 1'b1;
        load_setting(32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0, 32'h0);
        for (int i = 0; i < 8; i++) pending_steps.push_back(rand_step());
        repeat (4000) @(posedge clk);
        hold_off = 1'b0;
        wait_drained();

        // random phases with realistic and random settings
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph % 2 == 0)
                load_setting($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0001_0000),
                             $urandom_range(32'h100, 32'h0002_0000),
                             rand_q(), rand_q());
            else
                load_setting($urandom, $urandom, $urandom, $urandom, $urandom);
            for (int i = 0; i < 100; i++) pending_steps.push_back(rand_step());
            wait_drained();
        end

        stim_done = 1'b1;
        $display("covered %0d results (%0d held), 11 register settings incl. extremes",
                 results_seen, held_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rkds_pkg.sv
rtl/rkds_ifs.sv
rtl/rkds_mul.sv
rtl/rkds_tdiv.sv
rtl/rk4_driven_spring_step_top.sv
dv/rkds_tb_ifs_note.sv
dv/rk4_driven_spring_step_top_tb.sv
